/* hw/rtl/mbbt_pkg.sv */
// Package for the mask bounding box tracker: payload structs, internal
// control structs, reset values and register codes. No dependencies.
package mbbt_pkg;

   localparam int COORD_W = 11;
   localparam int PIX_W = 10;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH = 2'd1;
   localparam logic [1:0] CSR_MARGIN = 2'd2;
   localparam logic [1:0] CSR_CROSSING_LINE = 2'd3;

   localparam logic [COORD_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [COORD_W-1:0] WIDTH_RESET = 11'd640;
   localparam logic [PIX_W-1:0] MARGIN_RESET = 10'd75;
   localparam logic [COORD_W-1:0] LINE_RESET = 11'd240;

   localparam logic [7:0] REPS_MAX = 8'd255;
   localparam logic [7:0] REPS_TARGET = 8'd3;

   typedef struct packed {
      logic [PIX_W-1:0] row;
      logic [PIX_W-1:0] col;
      logic is_hand;
      logic frame_end;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] box_top;
      logic [COORD_W-1:0] box_bottom;
      logic [COORD_W-1:0] box_left;
      logic [COORD_W-1:0] box_right;
      logic [7:0] rep_count;
      logic reps_done;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] bottom;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
   } box_type;

   typedef struct packed {
      logic [COORD_W-1:0] height;
      logic [COORD_W-1:0] width;
      logic [PIX_W-1:0] margin;
   } front_cfg_type;

   typedef struct packed {
      logic set_bottom;
      logic [COORD_W-1:0] bottom;
      logic set_right;
      logic [COORD_W-1:0] right;
   } cfg_ctrl_type;

endpackage

/* hw/rtl/mbbt_front.sv */
// Front of the tracker: tests each pixel against the edge windows, keeps
// the extreme hits and forms the next search box at frame end. Uses mbbt_pkg.
module mbbt_front import mbbt_pkg::*; (
   input logic clock,
   input logic reset,
   input req_type pix,
   input logic accept,
   input front_cfg_type cfg,
   input cfg_ctrl_type ctl,
   output logic push,
   output box_type box_out
);

   box_type cur_ff, cur_in;
   logic [PIX_W-1:0] min_row_ff, max_row_ff, min_col_ff, max_col_ff;
   logic [PIX_W-1:0] min_row_in, max_row_in, min_col_in, max_col_in;
   logic [3:0] ok_ff, ok_in;

   logic [COORD_W-1:0] row_x, col_x, badj, radj, bot_sum, rgt_sum;
   logic hit_top, hit_bot, hit_lft, hit_rgt, rin;
   logic [PIX_W-1:0] min_row_n, max_row_n, min_col_n, max_col_n;
   logic [3:0] ok_n;
   box_type nbox;

   always_comb begin
      row_x = {1'b0, pix.row};
      col_x = {1'b0, pix.col};
      badj = (cur_ff.bottom == cfg.height) ? cur_ff.bottom - 11'd1 : cur_ff.bottom;
      radj = (cur_ff.right == cfg.width) ? cur_ff.right - 11'd1 : cur_ff.right;
      rin = pix.is_hand && (row_x >= cur_ff.top);
      hit_top = rin && (row_x < cur_ff.bottom) && (col_x > cur_ff.left)
         && (col_x < cur_ff.right);
      hit_bot = rin && (row_x <= badj) && (col_x >= cur_ff.left) && (col_x < cur_ff.right);
      hit_lft = rin && (row_x < badj) && (col_x >= cur_ff.left) && (col_x < cur_ff.right);
      hit_rgt = rin && (row_x < badj) && (col_x >= cur_ff.left) && (col_x <= radj);

      min_row_n = (hit_top && (!ok_ff[0] || pix.row < min_row_ff)) ? pix.row : min_row_ff;
      max_row_n = (hit_bot && (!ok_ff[1] || pix.row > max_row_ff)) ? pix.row : max_row_ff;
      min_col_n = (hit_lft && (!ok_ff[2] || pix.col < min_col_ff)) ? pix.col : min_col_ff;
      max_col_n = (hit_rgt && (!ok_ff[3] || pix.col > max_col_ff)) ? pix.col : max_col_ff;
      ok_n = ok_ff | {hit_rgt, hit_lft, hit_bot, hit_top};

      bot_sum = {1'b0, max_row_n} + {1'b0, cfg.margin};
      rgt_sum = {1'b0, max_col_n} + {1'b0, cfg.margin};

      nbox.top = cur_ff.top;
      if (ok_n[0]) begin
         nbox.top = (min_row_n < cfg.margin) ? '0 : {1'b0, min_row_n - cfg.margin};
      end
      nbox.bottom = badj;
      if (ok_n[1]) begin
         nbox.bottom = (bot_sum > cfg.height) ? cfg.height : bot_sum;
      end
      nbox.left = cur_ff.left;
      if (ok_n[2]) begin
         nbox.left = (min_col_n < cfg.margin) ? '0 : {1'b0, min_col_n - cfg.margin};
      end
      nbox.right = radj;
      if (ok_n[3]) begin
         nbox.right = (rgt_sum > cfg.width) ? cfg.width : rgt_sum;
      end

      push = accept && pix.frame_end;
      box_out = nbox;

      cur_in = cur_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      ok_in = ok_ff;
      if (accept) begin
         min_row_in = min_row_n;
         max_row_in = max_row_n;
         min_col_in = min_col_n;
         max_col_in = max_col_n;
         ok_in = ok_n;
         if (pix.frame_end) begin
            cur_in = nbox;
            ok_in = '0;
         end
      end
      if (ctl.set_bottom) begin
         cur_in.bottom = ctl.bottom;
      end
      if (ctl.set_right) begin
         cur_in.right = ctl.right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.top <= '0;
         cur_ff.bottom <= HEIGHT_RESET - 11'd1;
         cur_ff.left <= '0;
         cur_ff.right <= WIDTH_RESET - 11'd1;
         ok_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         ok_ff <= ok_in;
      end
      min_row_ff <= min_row_in;
      max_row_ff <= max_row_in;
      min_col_ff <= min_col_in;
      max_col_ff <= max_col_in;
   end

endmodule

/* hw/rtl/mbbt_queue.sv */
// Two-entry queue of finished boxes between front and back.
// Uses mbbt_pkg for box_type.
module mbbt_queue import mbbt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push,
   input box_type push_box,
   input logic pop,
   output logic full,
   output logic not_empty,
   output box_type head
);

   box_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_box;
      end
   end

endmodule

/* hw/rtl/mbbt_back.sv */
// Back of the tracker: takes a box from the queue, updates the repetition
// counter from its centre and holds the result beat. Uses mbbt_pkg.
module mbbt_back import mbbt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic q_not_empty,
   input box_type q_head,
   input logic [COORD_W-1:0] crossing_line,
   output logic q_pop,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data
);

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic [7:0] reps_ff, reps_in;
   logic up_ff, up_in;
   logic signed [12:0] diff, half, centre, line_x;

   always_comb begin
      diff = $signed({2'b0, q_head.bottom}) - $signed({2'b0, q_head.top});
      half = (diff + $signed({12'd0, diff[12]})) >>> 1;
      centre = half + $signed({2'b0, q_head.top});
      line_x = $signed({2'b0, crossing_line});
      q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);

      reps_in = reps_ff;
      up_in = up_ff;
      if (up_ff) begin
         if (centre >= line_x) begin
            if (reps_ff != REPS_MAX) begin
               reps_in = reps_ff + 8'd1;
            end
            up_in = 1'b0;
         end
      end else if (centre < line_x) begin
         up_in = 1'b1;
      end

      rsp_data_in.box_top = q_head.top;
      rsp_data_in.box_bottom = q_head.bottom;
      rsp_data_in.box_left = q_head.left;
      rsp_data_in.box_right = q_head.right;
      rsp_data_in.rep_count = reps_in;
      rsp_data_in.reps_done = (reps_in == REPS_TARGET);

      rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reps_ff <= '0;
         up_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            reps_ff <= reps_in;
            up_ff <= up_in;
         end
      end
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

/* hw/rtl/mask_bounding_box_tracker_unit.sv */
// Top level of the mask bounding box tracker: register port, front, queue
// and back. Uses mbbt_pkg, mbbt_front, mbbt_queue and mbbt_back.
//
//   channel  dir  handshake           beat
//   req_     in   req_valid/ready     one pixel (row, col, is_hand, frame_end)
//   rsp_     out  rsp_valid/ready     one box and rep count per frame end
//   csr_     in   psel/penable/pready four 32-bit registers at 0x0..0xC
//
// One pixel per cycle while req_ready is high; the front updates the hit
// extremes when a pixel is taken and the search box when a frame-end pixel
// is taken. That box goes through a two-entry queue to the back, which
// registers the result beat as it pops the box. req_ready drops only while
// the queue is full under a stalled rsp_ready. Reset is synchronous; no clearing pass.
module mask_bounding_box_tracker_unit import mbbt_pkg::*; #(
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_WIDTH = 1024
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   logic [COORD_W-1:0] height_ff, height_in, width_ff, width_in, line_ff, line_in;
   logic [PIX_W-1:0] margin_ff, margin_in;
   logic csr_wr;
   logic [1:0] csr_idx;
   logic [COORD_W-1:0] wval;
   front_cfg_type fcfg;
   cfg_ctrl_type ctl;
   logic accept, push, q_full, q_not_empty, q_pop;
   box_type push_box, q_head;

   always_comb begin
      csr_pready = 1'b1;
      csr_wr = csr_psel && csr_penable && csr_pwrite;
      csr_idx = csr_paddr[3:2];
      wval = csr_pwdata[COORD_W-1:0];
      height_in = height_ff;
      width_in = width_ff;
      margin_in = margin_ff;
      line_in = line_ff;
      ctl = '0;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_FRAME_HEIGHT: begin
               if (wval == '0) begin
                  height_in = 11'd1;
               end else if ({2'b0, wval} > 13'(MAX_HEIGHT)) begin
                  height_in = 11'(MAX_HEIGHT);
               end else begin
                  height_in = wval;
               end
               ctl.set_bottom = 1'b1;
               ctl.bottom = height_in - 11'd1;
            end
            CSR_FRAME_WIDTH: begin
               if (wval == '0) begin
                  width_in = 11'd1;
               end else if ({2'b0, wval} > 13'(MAX_WIDTH)) begin
                  width_in = 11'(MAX_WIDTH);
               end else begin
                  width_in = wval;
               end
               ctl.set_right = 1'b1;
               ctl.right = width_in - 11'd1;
            end
            CSR_MARGIN: begin
               margin_in = csr_pwdata[PIX_W-1:0];
            end
            CSR_CROSSING_LINE: begin
               line_in = wval;
            end
            default: begin
            end
         endcase
      end
      csr_prdata = '0;
      unique case (csr_idx)
         CSR_FRAME_HEIGHT: csr_prdata = {21'd0, height_ff};
         CSR_FRAME_WIDTH: csr_prdata = {21'd0, width_ff};
         CSR_MARGIN: csr_prdata = {22'd0, margin_ff};
         CSR_CROSSING_LINE: csr_prdata = {21'd0, line_ff};
         default: csr_prdata = '0;
      endcase
      fcfg.height = height_ff;
      fcfg.width = width_ff;
      fcfg.margin = margin_ff;
      req_ready = !q_full;
      accept = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HEIGHT_RESET;
         width_ff <= WIDTH_RESET;
         margin_ff <= MARGIN_RESET;
         line_ff <= LINE_RESET;
      end else begin
         height_ff <= height_in;
         width_ff <= width_in;
         margin_ff <= margin_in;
         line_ff <= line_in;
      end
   end

   mbbt_front u_front (
      .clock(clock),
      .reset(reset),
      .pix(req_data),
      .accept(accept),
      .cfg(fcfg),
      .ctl(ctl),
      .push(push),
      .box_out(push_box)
   );

   mbbt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_box(push_box),
      .pop(q_pop),
      .full(q_full),
      .not_empty(q_not_empty),
      .head(q_head)
   );

   mbbt_back u_back (
      .clock(clock),
      .reset(reset),
      .q_not_empty(q_not_empty),
      .q_head(q_head),
      .crossing_line(line_ff),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule
